// ===== hdl/address_auth_throttle_table_core_macros.svh =====
// assertion macros for the throttle table checker
// used by the checker file only, no other dependencies
`ifndef ADDRESS_AUTH_THROTTLE_TABLE_CORE_MACROS_SVH
`define ADDRESS_AUTH_THROTTLE_TABLE_CORE_MACROS_SVH

// same-cycle implication, reset masked
`define AAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define AAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/aat_pkg.sv =====
// shared constants, record types and helper functions of the throttle table
// no dependencies
`timescale 1ns / 1ps

package aat_pkg;

  localparam int SETS       = 16;
  localparam int WAYS       = 4;
  localparam int PRUNE_SETS = 2;
  localparam int EVICT_SETS = 4;
  localparam int EVICT_N    = (EVICT_SETS < SETS) ? EVICT_SETS : SETS;
  localparam int SET_W      = $clog2(SETS);
  localparam int WAY_W      = $clog2(WAYS);
  localparam int SLOT_W     = SET_W + WAY_W;
  localparam int NSLOT      = SETS * WAYS;
  localparam int CNT_W      = 5;

  localparam logic [63:0] HASH_ADD = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_MUL = 64'hFF51AFD7ED558CCD;

  localparam logic [2:0] KIND_BEGIN  = 3'd0;
  localparam logic [2:0] KIND_FINISH = 3'd1;
  localparam logic [2:0] KIND_RESET  = 3'd2;
  localparam logic [2:0] KIND_QUERY  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic [1:0] ADM_UNTRACKED = 2'd0;
  localparam logic [1:0] ADM_LOCKED    = 2'd1;
  localparam logic [1:0] ADM_TOO_MANY  = 2'd2;
  localparam logic [1:0] ADM_RESERVED  = 2'd3;

  localparam logic [1:0] LST_NOT_LOCKED = 2'd0;
  localparam logic [1:0] LST_ALREADY    = 2'd1;
  localparam logic [1:0] LST_LOCKED_NOW = 2'd2;

  localparam logic [1:0] CFG_MAX_ATTEMPTS    = 2'd0;
  localparam logic [1:0] CFG_LOCKOUT_SECONDS = 2'd1;
  localparam logic [1:0] CFG_MAX_TRACKED     = 2'd2;

  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [7:0]  failures;
    logic [7:0]  in_flight;
    logic [31:0] last_failure;
    logic [31:0] locked_until;
  } slot_t;

  typedef struct packed {
    logic [1:0]  admission;
    logic [1:0]  lock_state;
    logic        entry_found;
    logic [15:0] lockout_left;
    logic [7:0]  in_flight_now;
  } result_t;

  typedef struct packed {
    logic write;
    logic drop;
  } apply_ctl_t;

  function automatic logic is_locked(slot_t rec, logic [31:0] now);
    return rec.locked_until > now;
  endfunction

  function automatic logic is_stale(slot_t rec, logic [31:0] now, logic [15:0] lockout);
    logic [31:0] since;
    since = (now >= rec.last_failure) ? (now - rec.last_failure) : 32'd0;
    return since >= {16'd0, lockout};
  endfunction

  function automatic logic is_idle(slot_t rec, logic [31:0] now, logic [15:0] lockout);
    return (rec.in_flight == 8'd0) && !is_locked(rec, now) &&
           ((rec.failures == 8'd0) || is_stale(rec, now, lockout));
  endfunction

endpackage

// ===== hdl/address_auth_throttle_table_core.sv =====
// per-address login throttle table: one item at a time
// steps: hash, prune on begin, lookup way by way in the hashed set, eviction scans and
// insert when needed, then update and present the result
// reset clears valid bits, live count, cursor and output valid and loads the config defaults;
// slot memory keeps contents, entries are read only when their valid bit is set
`timescale 1ns / 1ps

module address_auth_throttle_table_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,   // addr_hi, addr_lo, was_reserved, failed, now_seconds
  input  logic [2:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // admission, lock_state, entry_found, lockout_left,
                                   // in_flight_now, tracked_count
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_HASH, ST_PRUNE_RD, ST_PRUNE_EV, ST_FIND_RD, ST_FIND_EV, ST_EVG_RD,
    ST_EVG_EV, ST_INS, ST_EVS_RD, ST_EVS_EV, ST_APPLY, ST_DONE
  } state_t;

  localparam int SW = aat_pkg::SET_W;
  localparam int WW = aat_pkg::WAY_W;
  localparam int LW = aat_pkg::SLOT_W;
  localparam int CW = aat_pkg::CNT_W;

  state_t state_r;
  logic [7:0]  max_attempts_r;
  logic [15:0] lockout_seconds_r;
  logic [6:0]  max_tracked_r;

  logic [aat_pkg::NSLOT-1:0] slot_valid_r;
  logic [SW-1:0] scan_cursor_r;
  logic [6:0]    live_count_r;

  logic [2:0]  kind_r;
  logic [63:0] key_hi_r;
  logic [63:0] key_lo_r;
  logic        reserved_r;
  logic        failed_r;
  logic [31:0] now_r;

  logic [SW-1:0] hset_r;
  logic [SW-1:0] set_r;
  logic [WW-1:0] way_r;
  logic [CW-1:0] cnt_r;
  logic          ins_pass_r;
  logic          found_r;
  logic [LW-1:0] slot_r;
  aat_pkg::slot_t   cur_r;
  aat_pkg::result_t res_r;

  logic          vic_valid_r;
  logic          vic_locked_r;
  logic [31:0]   vic_fail_r;
  logic [LW-1:0] vic_slot_r;

  logic        out_tvalid_r;
  logic [39:0] out_tdata_r;

  aat_pkg::slot_t mem [aat_pkg::NSLOT];
  aat_pkg::slot_t ram_q;

  logic          hash_done;
  logic [SW-1:0] hash_set;
  logic          hash_start;
  logic [63:0]   in_hi;
  logic [63:0]   in_lo;
  logic          in_mapped;

  aat_pkg::slot_t      ap_rec;
  aat_pkg::apply_ctl_t ap_ctl;
  aat_pkg::result_t    ap_res;

  logic [LW-1:0] idx;
  logic          idx_valid;
  logic          key_match;
  logic          cand_ok;
  logic          cand_idle;
  logic          cand_locked;
  logic          cand_take;
  logic          vic_any;
  logic [LW-1:0] vic_pick;
  logic [6:0]    limit;
  logic          need_create;
  logic          free_any;
  logic [WW-1:0] free_way;
  logic          rd_en;
  logic          wr_en;

  assign in_hi      = in_tdata[63:0];
  assign in_mapped  = (in_hi == 64'd0) && (in_tdata[127:96] == 32'h0000FFFF);
  assign in_lo      = in_mapped ? in_tdata[127:64] : 64'd0;
  assign in_tready  = (state_r == ST_IDLE);
  assign hash_start = in_tvalid && in_tready;

  aat_hash u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .key_hi  (in_hi),
    .key_lo  (in_lo),
    .done    (hash_done),
    .set_idx (hash_set)
  );

  aat_apply u_apply (
    .kind            (kind_r),
    .found           (found_r),
    .was_reserved    (reserved_r),
    .failed          (failed_r),
    .now             (now_r),
    .max_attempts    (max_attempts_r),
    .lockout_seconds (lockout_seconds_r),
    .cur             (cur_r),
    .rec_nxt         (ap_rec),
    .ctl             (ap_ctl),
    .res             (ap_res)
  );

  always_comb begin
    idx         = {set_r, way_r};
    idx_valid   = slot_valid_r[idx];
    key_match   = idx_valid && (ram_q.key_hi == key_hi_r) && (ram_q.key_lo == key_lo_r);
    cand_ok     = idx_valid && (ram_q.in_flight == 8'd0);
    cand_idle   = aat_pkg::is_idle(ram_q, now_r, lockout_seconds_r);
    cand_locked = aat_pkg::is_locked(ram_q, now_r);
    cand_take   = cand_ok && (!vic_valid_r || (vic_locked_r && !cand_locked) ||
                  ((vic_locked_r == cand_locked) && (ram_q.last_failure < vic_fail_r)));
    vic_any     = vic_valid_r || cand_take;
    vic_pick    = cand_take ? idx : vic_slot_r;
    limit       = (max_tracked_r == 7'd0) ? 7'd1 : max_tracked_r;
    need_create = (kind_r == aat_pkg::KIND_BEGIN) ||
                  ((kind_r == aat_pkg::KIND_FINISH) && failed_r && (max_attempts_r != 8'd0));
    free_any    = 1'b0;
    free_way    = '0;
    for (int w = aat_pkg::WAYS - 1; w >= 0; w--) begin
      if (!slot_valid_r[{hset_r, WW'(w)}]) begin
        free_any = 1'b1;
        free_way = WW'(w);
      end
    end
    rd_en = (state_r == ST_PRUNE_RD) || (state_r == ST_FIND_RD) ||
            (state_r == ST_EVG_RD) || (state_r == ST_EVS_RD);
    wr_en = (state_r == ST_APPLY) && ap_ctl.write && !ap_ctl.drop;
  end

  always_ff @(posedge clk) begin
    if (rd_en) ram_q <= mem[idx];
    if (wr_en) mem[slot_r] <= ap_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      max_attempts_r    <= 8'd5;
      lockout_seconds_r <= 16'd900;
      max_tracked_r     <= 7'd64;
      slot_valid_r      <= '0;
      scan_cursor_r     <= '0;
      live_count_r      <= '0;
      out_tvalid_r      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          aat_pkg::CFG_MAX_ATTEMPTS:    max_attempts_r    <= cfg_wdata[7:0];
          aat_pkg::CFG_LOCKOUT_SECONDS: lockout_seconds_r <= cfg_wdata;
          aat_pkg::CFG_MAX_TRACKED:     max_tracked_r     <= cfg_wdata[6:0];
          default: begin
          end
        endcase
      end
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) out_tvalid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            kind_r     <= in_tuser;
            key_hi_r   <= in_hi;
            key_lo_r   <= in_lo;
            reserved_r <= in_tdata[128];
            failed_r   <= in_tdata[129];
            now_r      <= in_tdata[161:130];
            found_r    <= 1'b0;
            ins_pass_r <= 1'b0;
            res_r      <= '0;
            state_r    <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            hset_r <= hash_set;
            way_r  <= '0;
            cnt_r  <= '0;
            priority if (kind_r == aat_pkg::KIND_CLEAR) begin
              slot_valid_r  <= '0;
              scan_cursor_r <= '0;
              live_count_r  <= '0;
              state_r       <= ST_DONE;
            end else if (kind_r == aat_pkg::KIND_BEGIN) begin
              if (max_attempts_r == 8'd0) begin
                state_r <= ST_DONE;
              end else if (live_count_r != 7'd0) begin
                set_r         <= scan_cursor_r;
                scan_cursor_r <= scan_cursor_r + 1'b1;
                state_r       <= ST_PRUNE_RD;
              end else begin
                set_r   <= hash_set;
                state_r <= ST_FIND_RD;
              end
            end else if (kind_r == aat_pkg::KIND_FINISH || kind_r == aat_pkg::KIND_RESET ||
                         kind_r == aat_pkg::KIND_QUERY) begin
              set_r   <= hash_set;
              state_r <= ST_FIND_RD;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_PRUNE_RD: state_r <= ST_PRUNE_EV;
        ST_PRUNE_EV: begin
          if (idx_valid && cand_idle) begin
            slot_valid_r[idx] <= 1'b0;
            live_count_r      <= live_count_r - 7'd1;
          end
          way_r <= way_r + 1'b1;
          if ((way_r == WW'(aat_pkg::WAYS - 1)) &&
              (cnt_r == CW'(aat_pkg::PRUNE_SETS - 1))) begin
            set_r   <= hset_r;
            state_r <= ST_FIND_RD;
          end else begin
            state_r <= ST_PRUNE_RD;
            if (way_r == WW'(aat_pkg::WAYS - 1)) begin
              cnt_r         <= cnt_r + 1'b1;
              set_r         <= scan_cursor_r;
              scan_cursor_r <= scan_cursor_r + 1'b1;
            end
          end
        end
        ST_FIND_RD: state_r <= ST_FIND_EV;
        ST_FIND_EV: begin
          if (key_match) begin
            found_r <= 1'b1;
            cur_r   <= ram_q;
            slot_r  <= idx;
            state_r <= ST_APPLY;
          end else if (way_r == WW'(aat_pkg::WAYS - 1)) begin
            if (!need_create) begin
              state_r <= ST_APPLY;
            end else if (live_count_r >= limit) begin
              cnt_r         <= '0;
              way_r         <= '0;
              vic_valid_r   <= 1'b0;
              set_r         <= scan_cursor_r;
              scan_cursor_r <= scan_cursor_r + 1'b1;
              state_r       <= ST_EVG_RD;
            end else begin
              state_r <= ST_INS;
            end
          end else begin
            way_r   <= way_r + 1'b1;
            state_r <= ST_FIND_RD;
          end
        end
        ST_EVG_RD: state_r <= ST_EVG_EV;
        ST_EVG_EV: begin
          vic_valid_r  <= vic_any;
          if (cand_take) begin
            vic_locked_r <= cand_locked;
            vic_fail_r   <= ram_q.last_failure;
            vic_slot_r   <= idx;
          end
          way_r <= way_r + 1'b1;
          if (cand_ok && cand_idle) begin
            slot_valid_r[idx] <= 1'b0;
            live_count_r      <= live_count_r - 7'd1;
            state_r           <= ST_INS;
          end else if ((way_r == WW'(aat_pkg::WAYS - 1)) &&
                       (cnt_r == CW'(aat_pkg::EVICT_N - 1))) begin
            if (vic_any) begin
              slot_valid_r[vic_pick] <= 1'b0;
              live_count_r           <= live_count_r - 7'd1;
              state_r                <= ST_INS;
            end else begin
              state_r <= ST_APPLY;
            end
          end else begin
            state_r <= ST_EVG_RD;
            if (way_r == WW'(aat_pkg::WAYS - 1)) begin
              cnt_r         <= cnt_r + 1'b1;
              set_r         <= scan_cursor_r;
              scan_cursor_r <= scan_cursor_r + 1'b1;
            end
          end
        end
        ST_INS: begin
          if (free_any) begin
            slot_valid_r[{hset_r, free_way}] <= 1'b1;
            live_count_r <= live_count_r + 7'd1;
            cur_r        <= '{key_hi: key_hi_r, key_lo: key_lo_r, default: '0};
            slot_r       <= {hset_r, free_way};
            found_r      <= 1'b1;
            state_r      <= ST_APPLY;
          end else if (!ins_pass_r) begin
            ins_pass_r  <= 1'b1;
            set_r       <= hset_r;
            way_r       <= '0;
            vic_valid_r <= 1'b0;
            state_r     <= ST_EVS_RD;
          end else begin
            state_r <= ST_APPLY;
          end
        end
        ST_EVS_RD: state_r <= ST_EVS_EV;
        ST_EVS_EV: begin
          vic_valid_r <= vic_any;
          if (cand_take) begin
            vic_locked_r <= cand_locked;
            vic_fail_r   <= ram_q.last_failure;
            vic_slot_r   <= idx;
          end
          way_r <= way_r + 1'b1;
          if (cand_ok && cand_idle) begin
            slot_valid_r[idx] <= 1'b0;
            live_count_r      <= live_count_r - 7'd1;
            state_r           <= ST_INS;
          end else if (way_r == WW'(aat_pkg::WAYS - 1)) begin
            if (vic_any) begin
              slot_valid_r[vic_pick] <= 1'b0;
              live_count_r           <= live_count_r - 7'd1;
              state_r                <= ST_INS;
            end else begin
              state_r <= ST_APPLY;
            end
          end else begin
            state_r <= ST_EVS_RD;
          end
        end
        ST_APPLY: begin
          res_r <= ap_res;
          if (ap_ctl.drop) begin
            slot_valid_r[slot_r] <= 1'b0;
            live_count_r         <= live_count_r - 7'd1;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {4'd0, live_count_r, res_r.in_flight_now, res_r.lockout_left,
                             res_r.entry_found, res_r.lock_state, res_r.admission};
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== hdl/aat_hash.sv =====
// set index hash of a key: 37-bit mix, split multiply over two stages
// depends on aat_pkg
`timescale 1ns / 1ps

module aat_hash (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [63:0]             key_hi,
  input  logic [63:0]             key_lo,
  output logic                    done,
  output logic [aat_pkg::SET_W-1:0] set_idx
);

  logic [2:0]  vld_r;
  logic [36:0] x_r;
  logic [37:0] pac_r;
  logic [36:0] pad_r;
  logic [36:0] pbc_r;
  logic [36:0] x_nxt;
  logic [36:0] m;
  logic [36:0] cross_sum;
  logic [aat_pkg::SET_W-1:0] set_r;

  localparam logic [36:0] MUL37 = aat_pkg::HASH_MUL[36:0];
  localparam logic [36:0] ADD37 = aat_pkg::HASH_ADD[36:0];

  // only the low 37 bits of the product reach the set index
  assign x_nxt     = key_hi[36:0] ^ (key_lo[36:0] + ADD37 + {key_hi[30:0], 6'b0} + key_hi[38:2]);
  assign cross_sum = pad_r + pbc_r;
  assign m         = pac_r[36:0] + {cross_sum[17:0], 19'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
    x_r   <= x_nxt;
    pac_r <= x_r[18:0] * MUL37[18:0];
    pad_r <= 37'(x_r[18:0] * MUL37[36:19]);
    pbc_r <= 37'(x_r[36:19] * MUL37[18:0]);
    set_r <= m[aat_pkg::SET_W-1:0] ^ m[33 +: aat_pkg::SET_W];
  end

  assign done    = vld_r[2];
  assign set_idx = set_r;

endmodule

// ===== hdl/aat_apply.sv =====
// per-kind update of one slot record and the result fields of an item
// depends on aat_pkg
`timescale 1ns / 1ps

module aat_apply (
  input  logic [2:0]           kind,
  input  logic                 found,
  input  logic                 was_reserved,
  input  logic                 failed,
  input  logic [31:0]          now,
  input  logic [7:0]           max_attempts,
  input  logic [15:0]          lockout_seconds,
  input  aat_pkg::slot_t       cur,
  output aat_pkg::slot_t       rec_nxt,
  output aat_pkg::apply_ctl_t  ctl,
  output aat_pkg::result_t     res
);

  logic        locked;
  logic        stale;
  logic [7:0]  f_fresh;
  logic [7:0]  f_inc;
  logic [7:0]  inf_dec;
  logic [8:0]  load;
  logic [32:0] lock_end;
  logic [31:0] left32;

  always_comb begin
    locked   = aat_pkg::is_locked(cur, now);
    stale    = (cur.failures != 8'd0) && aat_pkg::is_stale(cur, now, lockout_seconds);
    f_fresh  = stale ? 8'd0 : cur.failures;
    f_inc    = (f_fresh == 8'hFF) ? f_fresh : f_fresh + 8'd1;
    load     = {1'b0, f_fresh} + {1'b0, cur.in_flight};
    lock_end = {1'b0, now} + {17'd0, lockout_seconds};
    left32   = cur.locked_until - now;
    inf_dec  = (was_reserved && cur.in_flight != 8'd0) ? cur.in_flight - 8'd1 : cur.in_flight;
    rec_nxt  = cur;
    ctl      = '0;
    res      = '0;
    unique case (kind)
      aat_pkg::KIND_BEGIN: begin
        if (found) begin
          ctl.write = 1'b1;
          if (locked) begin
            res.admission = aat_pkg::ADM_LOCKED;
          end else begin
            rec_nxt.failures = f_fresh;
            if (load >= {1'b0, max_attempts}) begin
              res.admission = aat_pkg::ADM_TOO_MANY;
            end else begin
              if (cur.in_flight != 8'hFF) rec_nxt.in_flight = cur.in_flight + 8'd1;
              res.admission = aat_pkg::ADM_RESERVED;
            end
          end
        end
      end
      aat_pkg::KIND_FINISH: begin
        if (found) begin
          ctl.write = 1'b1;
          rec_nxt.in_flight = inf_dec;
          if (!failed || max_attempts == 8'd0) begin
            ctl.drop = (cur.failures == 8'd0) && (inf_dec == 8'd0) && !locked;
          end else if (locked) begin
            res.lock_state = aat_pkg::LST_ALREADY;
          end else begin
            rec_nxt.failures     = f_inc;
            rec_nxt.last_failure = now;
            if (f_inc >= max_attempts) begin
              rec_nxt.failures     = 8'd0;
              rec_nxt.locked_until = lock_end[32] ? 32'hFFFFFFFF : lock_end[31:0];
              res.lock_state       = aat_pkg::LST_LOCKED_NOW;
            end
          end
        end
      end
      aat_pkg::KIND_RESET: begin
        if (found) begin
          res.entry_found = 1'b1;
          if (cur.in_flight == 8'd0) begin
            ctl.drop = 1'b1;
          end else begin
            ctl.write            = 1'b1;
            rec_nxt.failures     = 8'd0;
            rec_nxt.locked_until = 32'd0;
          end
        end
      end
      aat_pkg::KIND_QUERY: begin
        if (found) begin
          if (locked) res.lockout_left = (left32[31:16] != 16'd0) ? 16'hFFFF : left32[15:0];
          res.in_flight_now = cur.in_flight;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/aat_checker.sv =====
// port-level checks of the throttle table and their bind to the top level
// depends on address_auth_throttle_table_core_macros.svh
`timescale 1ns / 1ps
`include "address_auth_throttle_table_core_macros.svh"

module aat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  `AAT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `AAT_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken while busy")
  `AAT_ASSERT_IMP(a_count_range, out_tvalid, out_tdata[35:29] <= 7'd64, "tracked count too big")
  `AAT_ASSERT_IMP(a_lock_code, out_tvalid, !(out_tdata[3] && out_tdata[2]), "bad lock state")

endmodule

bind address_auth_throttle_table_core aat_checker u_aat_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb.sv =====
// self-checking bench for address_auth_throttle_table_core: random and directed
// begin/finish/reset/query/clear transfers checked against a table predictor
// depends on hdl/aat_pkg.sv and hdl/address_auth_throttle_table_core.sv
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        resv;
    logic        fail;
    logic [31:0] now;
  } req_t;

  typedef struct {
    logic [1:0]  adm;
    logic [1:0]  lst;
    logic        fnd;
    logic [15:0] left;
    logic [7:0]  infl;
    logic [6:0]  cnt;
  } verdict_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [39:0]  out_tdata;
  logic         cfg_wen = 0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_wdata = '0;

  address_auth_throttle_table_core dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  p_max_att;
  logic [15:0] p_lockout;
  logic [6:0]  p_max_trk;
  bit          t_valid [aat_pkg::NSLOT];
  logic [63:0] t_hi [aat_pkg::NSLOT];
  logic [63:0] t_lo [aat_pkg::NSLOT];
  logic [7:0]  t_fail [aat_pkg::NSLOT];
  logic [7:0]  t_infl [aat_pkg::NSLOT];
  logic [31:0] t_lastf [aat_pkg::NSLOT];
  logic [31:0] t_until [aat_pkg::NSLOT];
  int          cursor;
  int          live;

  req_t     pending_reqs[$];
  verdict_t awaited[$];
  req_t     cur;
  int       gap;
  bit       no_gaps;
  bit       no_stalls;
  int       stall;
  int       errors;
  int       accepted;
  int       results;
  int       quiet;
  req_t     pool[32];

  function automatic int set_hash(logic [63:0] hi, logic [63:0] lo);
    logic [63:0] m;
    m = (hi ^ (lo + aat_pkg::HASH_ADD + (hi << 6) + (hi >> 2))) * aat_pkg::HASH_MUL;
    m = m ^ (m >> 33);
    return int'(m % aat_pkg::SETS);
  endfunction

  function automatic bit idle_slot(int s, logic [31:0] now);
    logic [31:0] since;
    since = (now >= t_lastf[s]) ? now - t_lastf[s] : 32'd0;
    return t_infl[s] == 0 && t_until[s] <= now &&
           (t_fail[s] == 0 || since >= {16'd0, p_lockout});
  endfunction

  function automatic void drop_slot(int s);
    if (t_valid[s]) begin
      t_valid[s] = 0;
      live--;
    end
  endfunction

  function automatic int step_cursor();
    int set;
    set = cursor % aat_pkg::SETS;
    cursor = (set + 1) % aat_pkg::SETS;
    return set;
  endfunction

  function automatic int lookup(logic [63:0] hi, logic [63:0] lo);
    int base;
    base = set_hash(hi, lo) * aat_pkg::WAYS;
    for (int w = 0; w < aat_pkg::WAYS; w++)
      if (t_valid[base + w] && t_hi[base + w] == hi && t_lo[base + w] == lo) return base + w;
    return -1;
  endfunction

  function automatic void prune(logic [31:0] now);
    int cnt;
    int base;
    cnt = 0;
    if (live == 0) return;
    for (int n = 0; n < aat_pkg::PRUNE_SETS && cnt < 16; n++) begin
      base = step_cursor() * aat_pkg::WAYS;
      for (int w = 0; w < aat_pkg::WAYS && cnt < 16; w++)
        if (t_valid[base + w] && idle_slot(base + w, now)) begin
          drop_slot(base + w);
          cnt++;
        end
    end
  endfunction

  function automatic bit rate_set(int set, logic [31:0] now, inout int victim,
                                  inout bit vlocked, inout logic [31:0] vfail);
    int s;
    bit lk;
    for (int w = 0; w < aat_pkg::WAYS; w++) begin
      s = set * aat_pkg::WAYS + w;
      if (!t_valid[s] || t_infl[s] != 0) continue;
      if (idle_slot(s, now)) begin
        drop_slot(s);
        return 1;
      end
      lk = t_until[s] > now;
      if (victim < 0 || (vlocked && !lk) || (vlocked == lk && t_lastf[s] < vfail)) begin
        victim = s;
        vlocked = lk;
        vfail = t_lastf[s];
      end
    end
    return 0;
  endfunction

  function automatic bit evict(int own_set, logic [31:0] now);
    int victim;
    bit vlocked;
    logic [31:0] vfail;
    victim = -1;
    vlocked = 1;
    vfail = 0;
    if (own_set < 0) begin
      if (live == 0) return 0;
      for (int i = 0; i < aat_pkg::EVICT_N; i++)
        if (rate_set(step_cursor(), now, victim, vlocked, vfail)) return 1;
    end else if (rate_set(own_set, now, victim, vlocked, vfail)) return 1;
    if (victim < 0) return 0;
    drop_slot(victim);
    return 1;
  endfunction

  function automatic int claim(logic [63:0] hi, logic [63:0] lo, logic [31:0] now);
    int s;
    int set;
    int lim;
    s = lookup(hi, lo);
    lim = (p_max_trk == 0) ? 1 : p_max_trk;
    if (s >= 0) return s;
    if (live >= lim && !evict(-1, now)) return -1;
    set = set_hash(hi, lo);
    for (int pass = 0; pass < 2; pass++) begin
      for (int w = 0; w < aat_pkg::WAYS; w++) begin
        s = set * aat_pkg::WAYS + w;
        if (!t_valid[s]) begin
          t_valid[s] = 1;
          t_hi[s] = hi;
          t_lo[s] = lo;
          t_fail[s] = 0;
          t_infl[s] = 0;
          t_lastf[s] = 0;
          t_until[s] = 0;
          live++;
          return s;
        end
      end
      if (pass == 0 && !evict(set, now)) return -1;
    end
    return -1;
  endfunction

  function automatic void clear_stale(int s, logic [31:0] now);
    logic [31:0] since;
    since = (now >= t_lastf[s]) ? now - t_lastf[s] : 32'd0;
    if (t_fail[s] != 0 && since >= {16'd0, p_lockout}) t_fail[s] = 0;
  endfunction

  function automatic verdict_t throttle(req_t r);
    verdict_t v;
    logic [63:0] lo;
    logic [32:0] lock_end;
    logic [31:0] d;
    int s;
    v = '{default: '0};
    lo = (r.hi == 0 && r.lo[63:32] == 32'h0000FFFF) ? r.lo : 64'd0;
    case (r.kind)
      aat_pkg::KIND_BEGIN: if (p_max_att != 0) begin
        prune(r.now);
        s = claim(r.hi, lo, r.now);
        if (s >= 0) begin
          if (t_until[s] > r.now) v.adm = aat_pkg::ADM_LOCKED;
          else begin
            clear_stale(s, r.now);
            if (9'(t_fail[s]) + 9'(t_infl[s]) >= 9'(p_max_att)) v.adm = aat_pkg::ADM_TOO_MANY;
            else begin
              if (t_infl[s] != 8'hFF) t_infl[s]++;
              v.adm = aat_pkg::ADM_RESERVED;
            end
          end
        end
      end
      aat_pkg::KIND_FINISH: begin
        s = lookup(r.hi, lo);
        if (s >= 0 && r.resv && t_infl[s] > 0) t_infl[s]--;
        if (!r.fail || p_max_att == 0) begin
          if (s >= 0 && t_fail[s] == 0 && idle_slot(s, r.now)) drop_slot(s);
        end else begin
          if (s < 0) s = claim(r.hi, lo, r.now);
          if (s >= 0) begin
            if (t_until[s] > r.now) v.lst = aat_pkg::LST_ALREADY;
            else begin
              clear_stale(s, r.now);
              if (t_fail[s] != 8'hFF) t_fail[s]++;
              t_lastf[s] = r.now;
              if (t_fail[s] >= p_max_att) begin
                lock_end = {1'b0, r.now} + 33'(p_lockout);
                t_fail[s] = 0;
                t_until[s] = lock_end[32] ? 32'hFFFFFFFF : lock_end[31:0];
                v.lst = aat_pkg::LST_LOCKED_NOW;
              end
            end
          end
        end
      end
      aat_pkg::KIND_RESET: begin
        s = lookup(r.hi, lo);
        if (s >= 0) begin
          v.fnd = 1;
          if (t_infl[s] == 0) drop_slot(s);
          else begin
            t_fail[s] = 0;
            t_until[s] = 0;
          end
        end
      end
      aat_pkg::KIND_QUERY: begin
        s = lookup(r.hi, lo);
        if (s >= 0) begin
          if (t_until[s] > r.now) begin
            d = t_until[s] - r.now;
            v.left = (d > 32'hFFFF) ? 16'hFFFF : d[15:0];
          end
          v.infl = t_infl[s];
        end
      end
      aat_pkg::KIND_CLEAR: begin
        for (int i = 0; i < aat_pkg::NSLOT; i++) t_valid[i] = 0;
        cursor = 0;
        live = 0;
      end
      default: ;
    endcase
    v.cnt = 7'(live);
    return v;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited.push_back(throttle(cur));
        accepted++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_tvalid <= 0;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          in_tdata <= {6'd0, cur.now, cur.fail, cur.resv, cur.lo, cur.hi};
          in_tuser <= cur.kind;
          in_tvalid <= 1;
          gap <= no_gaps ? 0 : $urandom_range(0, 14);
        end else in_tvalid <= 0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    verdict_t e;
    verdict_t a;
    int s;
    if (!rst_n) begin
      out_tready <= 0;
      stall <= 0;
    end else if (out_tvalid && out_tready) begin
      results++;
      a.adm = out_tdata[1:0];
      a.lst = out_tdata[3:2];
      a.fnd = out_tdata[4];
      a.left = out_tdata[20:5];
      a.infl = out_tdata[28:21];
      a.cnt = out_tdata[35:29];
      if (awaited.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        e = awaited.pop_front();
        if (a != e) begin
          $display("%0t mismatch: expected adm %0d lst %0d fnd %0d left %0d infl %0d cnt %0d",
                   $time, e.adm, e.lst, e.fnd, e.left, e.infl, e.cnt);
          $display("%0t            actual adm %0d lst %0d fnd %0d left %0d infl %0d cnt %0d",
                   $time, a.adm, a.lst, a.fnd, a.left, a.infl, a.cnt);
          errors++;
        end
      end
      s = no_stalls ? 0 : $urandom_range(0, 14);
      stall <= s;
      out_tready <= (s == 0);
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_tready <= (stall == 1);
    end else out_tready <= 1;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 3000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic settle();
    wait (pending_reqs.size() == 0 && !in_tvalid && awaited.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_wen <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      aat_pkg::CFG_MAX_ATTEMPTS: p_max_att = val[7:0];
      aat_pkg::CFG_LOCKOUT_SECONDS: p_lockout = val;
      default: p_max_trk = val[6:0];
    endcase
    @(posedge clk);
    cfg_wen <= 0;
  endtask

  task automatic setup_regs(logic [7:0] att, logic [15:0] lock, logic [6:0] trk);
    settle();
    write_reg(aat_pkg::CFG_MAX_ATTEMPTS, {8'd0, att});
    write_reg(aat_pkg::CFG_LOCKOUT_SECONDS, lock);
    write_reg(aat_pkg::CFG_MAX_TRACKED, {9'd0, trk});
  endtask

  function automatic req_t make(logic [2:0] k, logic [63:0] hi, logic [63:0] lo,
                                logic rs, logic fl, logic [31:0] now);
    req_t r;
    r.kind = k;
    r.hi = hi;
    r.lo = lo;
    r.resv = rs;
    r.fail = fl;
    r.now = now;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic rand1();
    return 1'($urandom());
  endfunction

  task automatic fill_pool();
    for (int i = 0; i < 32; i++) begin
      case (i % 4)
        0: pool[i] = make(aat_pkg::KIND_BEGIN, 64'd0, {32'h0000FFFF, $urandom()}, 1'b0, 1'b0,
                          32'd0);
        1: pool[i] = make(aat_pkg::KIND_BEGIN, rand64(), rand64(), 1'b0, 1'b0, 32'd0);
        2: pool[i] = make(aat_pkg::KIND_BEGIN, 64'd0, rand64(), 1'b0, 1'b0, 32'd0);
        default: pool[i] = make(aat_pkg::KIND_BEGIN, pool[i - 2].hi, rand64(), 1'b0, 1'b0,
                                32'd0);
      endcase
    end
  endtask

  // mostly begin/finish pairs on a small address pool, with noise
  task automatic random_phase(int n, int span, inout logic [31:0] clock_s);
    req_t a;
    int r;
    for (int i = 0; i < n; i++) begin
      a = pool[$urandom_range(0, span - 1)];
      r = $urandom_range(0, 99);
      if (r < 5) clock_s = clock_s - $urandom_range(0, 50);
      else if (r < 8) clock_s = $urandom();
      else clock_s = clock_s + $urandom_range(0, 40);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        pending_reqs.push_back(make(aat_pkg::KIND_BEGIN, a.hi, a.lo, rand1(), rand1(), clock_s));
        pending_reqs.push_back(make(aat_pkg::KIND_FINISH, a.hi, a.lo,
                                    $urandom_range(0, 9) != 0, $urandom_range(0, 2) != 0,
                                    clock_s + $urandom_range(0, 3)));
        i++;
      end else if (r < 80) pending_reqs.push_back(make(aat_pkg::KIND_QUERY, a.hi, a.lo,
                                                       rand1(), rand1(), clock_s));
      else if (r < 86) pending_reqs.push_back(make(aat_pkg::KIND_RESET, a.hi, a.lo,
                                                   rand1(), rand1(), clock_s));
      else if (r < 88) pending_reqs.push_back(make(aat_pkg::KIND_CLEAR, rand64(), rand64(),
                                                   rand1(), rand1(), clock_s));
      else if (r < 90) pending_reqs.push_back(make(3'($urandom_range(5, 7)), rand64(),
                                                   rand64(), rand1(), rand1(), $urandom()));
      else pending_reqs.push_back(make(3'($urandom_range(0, 3)), rand64(), rand64(), rand1(),
                                       rand1(), clock_s));
    end
  endtask

  initial begin
    logic [31:0] clock_s;
    logic [63:0] v4;
    p_max_att = 5;
    p_lockout = 900;
    p_max_trk = 64;
    cursor = 0;
    live = 0;
    errors = 0;
    accepted = 0;
    results = 0;
    quiet = 0;
    no_gaps = 0;
    no_stalls = 0;
    for (int i = 0; i < aat_pkg::NSLOT; i++) t_valid[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed: lock an address, query, time reversal, reset, extremes, unused kinds, clear
    v4 = {32'h0000FFFF, 32'hC0A80001};
    for (int i = 0; i < 5; i++) begin
      pending_reqs.push_back(make(aat_pkg::KIND_BEGIN, 64'd0, v4, 1'b0, 1'b0, 32'd100));
      pending_reqs.push_back(make(aat_pkg::KIND_FINISH, 64'd0, v4, 1'b1, 1'b1, 32'd101));
    end
    pending_reqs.push_back(make(aat_pkg::KIND_BEGIN, 64'd0, v4, 1'b0, 1'b0, 32'd102));
    pending_reqs.push_back(make(aat_pkg::KIND_QUERY, 64'd0, v4, 1'b0, 1'b0, 32'd102));
    pending_reqs.push_back(make(aat_pkg::KIND_FINISH, 64'd0, v4, 1'b0, 1'b1, 32'd50));
    pending_reqs.push_back(make(aat_pkg::KIND_RESET, 64'd0, v4, 1'b0, 1'b0, 32'd103));
    pending_reqs.push_back(make(aat_pkg::KIND_BEGIN, '1, '1, 1'b1, 1'b1, 32'hFFFFFFFF));
    pending_reqs.push_back(make(aat_pkg::KIND_FINISH, '1, '1, 1'b1, 1'b1, 32'hFFFFFF00));
    pending_reqs.push_back(make(aat_pkg::KIND_QUERY, '1, 64'd0, 1'b1, 1'b1, 32'd0));
    pending_reqs.push_back(make(3'd5, '1, '1, 1'b1, 1'b1, '1));
    pending_reqs.push_back(make(3'd6, 64'd0, 64'd0, 1'b0, 1'b0, 32'd0));
    pending_reqs.push_back(make(3'd7, '1, '1, 1'b1, 1'b1, '1));
    pending_reqs.push_back(make(aat_pkg::KIND_RESET, 64'd0, 64'h0000FFFE_12345678, 1'b0, 1'b0,
                                32'd5));
    pending_reqs.push_back(make(aat_pkg::KIND_CLEAR, 64'd0, 64'd0, 1'b0, 1'b0, 32'd0));
    pending_reqs.push_back(make(aat_pkg::KIND_QUERY, 64'd0, v4, 1'b0, 1'b0, 32'd200));

    fill_pool();
    clock_s = 1000;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: setup_regs(8'd5, 16'd900, 7'd64);
        1: setup_regs(8'd1, 16'd0, 7'd1);
        2: setup_regs(8'd255, 16'hFFFF, 7'd64);
        3: setup_regs(8'd3, 16'd30, 7'd8);
        4: setup_regs(8'd0, 16'd20, 7'd0);
        5: setup_regs(8'd2, 16'd10, 7'd3);
        6: setup_regs(8'd4, 16'd60, 7'd16);
        7: setup_regs(8'd7, 16'd5, 7'd40);
        default: setup_regs(8'd2, 16'd120, 7'd6);
      endcase
      no_gaps = (ph == 3);
      no_stalls = (ph == 3 || ph == 6);
      if (ph == 2) clock_s = 32'hFFFFFE00;
      random_phase(130, (ph % 2) ? 32 : 12, clock_s);
    end

    wait (pending_reqs.size() == 0 && !in_tvalid && awaited.size() == 0);
    repeat (80) @(posedge clk);
    $display("tb: %0d transfers in, %0d results checked over nine register settings",
             accepted, results);
    $display("tb: covered lockout, saturation, eviction, time reversal and unused kinds");
    if (errors == 0 && awaited.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
